@@ hdl/fcd_pkg.sv @@
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the chunk deframer.
// ----------------------------------------------------------------------------
package fcd_pkg;

  typedef enum logic [1:0] {
    PH_COLLECT = 2'd0,
    PH_VIDEO   = 2'd1,
    PH_AUDIO   = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_CLEAN = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [15:0] MAGIC_VIDEO_A = 16'hF1FA;
  localparam logic [15:0] MAGIC_VIDEO_B = 16'hF5FA;
  localparam logic [15:0] MAGIC_AUDIO   = 16'hAAAA;

  localparam logic [31:0] PREAMBLE_LEN  = 32'd6;
  localparam logic [31:0] AUDIO_SUB_LEN = 32'd10;
  localparam int unsigned PRE_STORED    = 5;
  localparam logic [2:0]  PRE_LAST_IDX  = 3'd5;
  localparam logic [2:0]  BURST_LAST    = 3'd5;

  // One queue entry: a single result, or a burst of six preamble bytes.
  typedef struct packed {
    logic                  burst;
    logic [1:0]            status;
    logic [7:0]            data;
    logic                  audio;
    logic                  first;
    logic                  last;
    logic                  key;
    logic [31:0]           fn;
    logic [31:0]           size;
    logic [4:0][7:0]       pre;
  } cmd_t;

endpackage

@@ hdl/fcd_front.sv @@
// ----------------------------------------------------------------------------
// fcd_front
// Chunk parser: collects preambles, classifies chunks and queues results.
// ----------------------------------------------------------------------------
module fcd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic [7:0]    in_data,
  input  logic          q_full,
  output logic          q_push,
  output fcd_pkg::cmd_t q_cmd
);

  fcd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  pre_r [fcd_pkg::PRE_STORED];
  logic [2:0]  pre_cnt_r, pre_cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic        in_audio_r, in_audio_nxt;
  logic [31:0] vfc_r, vfc_nxt;

  logic        acc;
  logic        pre_done;
  logic [31:0] size_w;
  logic [15:0] magic_w;
  logic        is_video;
  logic        is_audio;
  logic        size_gt6;
  logic        rem_le1;
  logic [31:0] cur_fn;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign pre_done = (pre_cnt_r == fcd_pkg::PRE_LAST_IDX);
  assign size_w   = {pre_r[3], pre_r[2], pre_r[1], pre_r[0]};
  assign magic_w  = {in_data, pre_r[4]};
  assign size_gt6 = (size_w > fcd_pkg::PREAMBLE_LEN);
  assign is_video = ((magic_w == fcd_pkg::MAGIC_VIDEO_A) ||
                     (magic_w == fcd_pkg::MAGIC_VIDEO_B)) && size_gt6;
  assign is_audio = (magic_w == fcd_pkg::MAGIC_AUDIO);
  assign rem_le1  = (rem_r <= 32'd1);
  assign cur_fn   = vfc_r - 32'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_kind) begin
        phase_nxt = fcd_pkg::PH_COLLECT;
      end else begin
        case (phase_r)
          fcd_pkg::PH_COLLECT: begin
            if (pre_done) begin
              if (is_video) begin
                phase_nxt = fcd_pkg::PH_VIDEO;
              end else if (is_audio || size_gt6) begin
                phase_nxt = fcd_pkg::PH_SKIP;
              end else begin
                phase_nxt = fcd_pkg::PH_COLLECT;
              end
            end
          end
          fcd_pkg::PH_VIDEO, fcd_pkg::PH_AUDIO: begin
            if (rem_le1) begin
              phase_nxt = fcd_pkg::PH_COLLECT;
            end
          end
          fcd_pkg::PH_SKIP: begin
            if (rem_le1) begin
              if (in_audio_r && (clen_r != 32'd0)) begin
                phase_nxt = fcd_pkg::PH_AUDIO;
              end else begin
                phase_nxt = fcd_pkg::PH_COLLECT;
              end
            end
          end
          default: phase_nxt = fcd_pkg::PH_COLLECT;
        endcase
      end
    end
  end

  // datapath and queue outputs
  always_comb begin
    pre_cnt_nxt  = pre_cnt_r;
    rem_nxt      = rem_r;
    clen_nxt     = clen_r;
    in_audio_nxt = in_audio_r;
    vfc_nxt      = vfc_r;
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.pre    = {pre_r[4], pre_r[3], pre_r[2], pre_r[1], pre_r[0]};
    if (acc) begin
      if (in_kind) begin
        q_push       = 1'b1;
        q_cmd.status = ((phase_r == fcd_pkg::PH_COLLECT) && (pre_cnt_r == 3'd0)) ?
                       fcd_pkg::ST_CLEAN : fcd_pkg::ST_TRUNC;
        pre_cnt_nxt  = 3'd0;
        rem_nxt      = 32'd0;
        in_audio_nxt = 1'b0;
      end else begin
        case (phase_r)
          fcd_pkg::PH_COLLECT: begin
            if (!pre_done) begin
              pre_cnt_nxt = pre_cnt_r + 3'd1;
            end else begin
              pre_cnt_nxt = 3'd0;
              if (is_video) begin
                q_push       = 1'b1;
                q_cmd.burst  = 1'b1;
                q_cmd.status = fcd_pkg::ST_BYTE;
                q_cmd.data   = in_data;
                q_cmd.key    = (vfc_r == 32'd0);
                q_cmd.fn     = vfc_r;
                q_cmd.size   = size_w;
                vfc_nxt      = vfc_r + 32'd1;
                clen_nxt     = size_w;
                rem_nxt      = size_w - fcd_pkg::PREAMBLE_LEN;
                in_audio_nxt = 1'b0;
              end else if (is_audio) begin
                clen_nxt     = size_w;
                rem_nxt      = fcd_pkg::AUDIO_SUB_LEN;
                in_audio_nxt = 1'b1;
              end else begin
                in_audio_nxt = 1'b0;
                if (size_gt6) begin
                  rem_nxt = size_w - fcd_pkg::PREAMBLE_LEN;
                end
              end
            end
          end
          fcd_pkg::PH_VIDEO: begin
            q_push       = 1'b1;
            q_cmd.status = fcd_pkg::ST_BYTE;
            q_cmd.data   = in_data;
            q_cmd.last   = rem_le1;
            q_cmd.key    = (cur_fn == 32'd0);
            q_cmd.fn     = cur_fn;
            q_cmd.size   = clen_r;
            rem_nxt      = rem_le1 ? 32'd0 : rem_r - 32'd1;
          end
          fcd_pkg::PH_AUDIO: begin
            q_push       = 1'b1;
            q_cmd.status = fcd_pkg::ST_BYTE;
            q_cmd.data   = in_data;
            q_cmd.audio  = 1'b1;
            q_cmd.first  = (rem_r == clen_r);
            q_cmd.last   = rem_le1;
            q_cmd.key    = 1'b1;
            q_cmd.size   = clen_r;
            rem_nxt      = rem_le1 ? 32'd0 : rem_r - 32'd1;
            if (rem_le1) begin
              in_audio_nxt = 1'b0;
            end
          end
          fcd_pkg::PH_SKIP: begin
            if (!rem_le1) begin
              rem_nxt = rem_r - 32'd1;
            end else begin
              rem_nxt = 32'd0;
              if (in_audio_r) begin
                if (clen_r == 32'd0) begin
                  q_push       = 1'b1;
                  q_cmd.status = fcd_pkg::ST_EMPTY;
                  q_cmd.audio  = 1'b1;
                  q_cmd.first  = 1'b1;
                  q_cmd.last   = 1'b1;
                  q_cmd.key    = 1'b1;
                  in_audio_nxt = 1'b0;
                end else begin
                  rem_nxt = clen_r;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fcd_pkg::PH_COLLECT;
      pre_cnt_r  <= 3'd0;
      rem_r      <= 32'd0;
      clen_r     <= 32'd0;
      in_audio_r <= 1'b0;
      vfc_r      <= 32'd0;
    end else begin
      phase_r    <= phase_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      rem_r      <= rem_nxt;
      clen_r     <= clen_nxt;
      in_audio_r <= in_audio_nxt;
      vfc_r      <= vfc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_kind && (phase_r == fcd_pkg::PH_COLLECT) && !pre_done) begin
      pre_r[pre_cnt_r] <= in_data;
    end
  end

endmodule

@@ hdl/fcd_queue.sv @@
// ----------------------------------------------------------------------------
// fcd_queue
// Short register queue of parser commands between front and back.
// ----------------------------------------------------------------------------
module fcd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fcd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output fcd_pkg::cmd_t head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  fcd_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count above depth");

  a_ptr_gap : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CNT_FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");
`endif

endmodule

@@ hdl/fcd_back.sv @@
// ----------------------------------------------------------------------------
// fcd_back
// Expands queued commands into results and holds the output register.
// ----------------------------------------------------------------------------
module fcd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  fcd_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [7:0]    out_byte_out,
  output logic          out_stream_is_audio,
  output logic          out_first_of_packet,
  output logic          out_last_of_packet,
  output logic          out_keyframe,
  output logic [31:0]   out_frame_idx,
  output logic [31:0]   out_packet_size
);

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  beat_r, beat_nxt;
  logic        load;
  logic        beat_end;
  logic [7:0]  beat_byte;

  logic [1:0]  status_r;
  logic [7:0]  byte_r;
  logic        audio_r;
  logic        first_r;
  logic        last_r;
  logic        key_r;
  logic [31:0] fn_r;
  logic [31:0] size_r;

  assign load     = head_valid && (!out_valid_r || !out_stall);
  assign beat_end = !head_cmd.burst || (beat_r == fcd_pkg::BURST_LAST);
  assign pop      = load && beat_end;

  always_comb begin
    beat_byte = head_cmd.data;
    if (head_cmd.burst && (beat_r != fcd_pkg::BURST_LAST)) begin
      beat_byte = head_cmd.pre[beat_r];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    beat_nxt      = beat_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      beat_nxt      = beat_end ? 3'd0 : beat_r + 3'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= head_cmd.status;
      byte_r   <= beat_byte;
      audio_r  <= head_cmd.audio;
      first_r  <= head_cmd.burst ? (beat_r == 3'd0) : head_cmd.first;
      last_r   <= head_cmd.last;
      key_r    <= head_cmd.key;
      fn_r     <= head_cmd.fn;
      size_r   <= head_cmd.size;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_byte_out        = byte_r;
  assign out_stream_is_audio = audio_r;
  assign out_first_of_packet = first_r;
  assign out_last_of_packet  = last_r;
  assign out_keyframe        = key_r;
  assign out_frame_idx       = fn_r;
  assign out_packet_size     = size_r;

`ifndef SYNTH
  a_beat_on_burst : assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != 3'd0) |-> (head_valid && head_cmd.burst))
    else $error("burst beat without burst at queue head");

  a_beat_bound : assert property (@(posedge clk) disable iff (!rst_n)
    beat_r <= fcd_pkg::BURST_LAST)
    else $error("burst beat out of range");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=>
      (out_valid_r && $stable(byte_r) && $stable(status_r)))
    else $error("stalled result changed");
`endif

endmodule

@@ hdl/flic_chunk_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// flic_chunk_deframer_unit
// Chunk demultiplexer for the byte stream following a FLIC file header.
// ----------------------------------------------------------------------------
// Input channel (in_*): one stream byte per transfer (in_kind 0) or an end of
// stream marker (in_kind 1). Output channel (out_*): one result per transfer,
// payload bytes of video and audio packets, empty audio packets and end
// reports. Both channels transfer when valid is high and stall is low.
// The parser takes one byte per cycle while in_stall is low and writes at
// most one command per byte to a short queue; a video preamble becomes one
// burst command that the back end plays out as six results, so sustained
// output is one result per cycle while out_stall is low, set by the single
// output register. A result is registered in a queue entry and then in the
// output register before it is presented. A stalled output holds its
// register; the queue then fills and in_stall rises once it holds
// QUEUE_DEPTH commands. The default depth of eight covers the backlog of a
// video preamble burst, so in_stall stays low while the output flows. Reset
// empties the queue, drops the output and returns the parser to preamble
// collection with the video frame count at zero.
// ----------------------------------------------------------------------------
module flic_chunk_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_byte_out,
  output logic        out_stream_is_audio,
  output logic        out_first_of_packet,
  output logic        out_last_of_packet,
  output logic        out_keyframe,
  output logic [31:0] out_frame_idx,
  output logic [31:0] out_packet_size
);

  logic          q_full;
  logic          q_push;
  fcd_pkg::cmd_t q_cmd;
  logic          q_pop;
  logic          q_head_valid;
  fcd_pkg::cmd_t q_head;

  fcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  fcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  fcd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (q_head_valid),
    .head_cmd            (q_head),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_byte_out        (out_byte_out),
    .out_stream_is_audio (out_stream_is_audio),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_keyframe        (out_keyframe),
    .out_frame_idx       (out_frame_idx),
    .out_packet_size     (out_packet_size)
  );

endmodule

@@ bench/flic_chunk_deframer_unit_test.sv @@
// ----------------------------------------------------------------------------
// flic_chunk_deframer_unit_test
// Self-checking bench for the chunk deframer. A short directed opening covers
// a clean end, the smallest video chunk on frame zero, an empty audio chunk
// and a cut preamble. Random chunk streams follow: video, audio, skipped and
// undersized chunks, oversized chunks and noise cut off by end markers. The
// idling pattern changes over three stretches. Every input transfer updates a
// behavioural copy of the parser, which queues the results it should produce.
// Every output transfer is checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
module flic_chunk_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data;
    logic        audio;
    logic        first;
    logic        last;
    logic        key;
    logic [31:0] fn;
    logic [31:0] size;
  } chunk_result_t;

  class chunk_stream_checker;
    fcd_pkg::phase_t phase;
    logic [7:0]      pre_bytes [5];
    int unsigned     pre_count;
    logic [31:0]     remaining;
    logic [31:0]     chunk_len;
    bit              audio_next;
    logic [31:0]     frame_count;
    chunk_result_t   due_results [$];
    int unsigned     errors;
    int unsigned     items_taken;

    function new();
      phase       = fcd_pkg::PH_COLLECT;
      pre_count   = 0;
      remaining   = '0;
      chunk_len   = '0;
      audio_next  = 1'b0;
      frame_count = '0;
      errors      = 0;
      items_taken = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function void queue_result(logic [1:0] status, logic [7:0] data, logic audio,
                               logic first, logic last, logic key,
                               logic [31:0] fn, logic [31:0] size);
      chunk_result_t r;
      r.status = status;
      r.data   = data;
      r.audio  = audio;
      r.first  = first;
      r.last   = last;
      r.key    = key;
      r.fn     = fn;
      r.size   = size;
      due_results.push_back(r);
    endfunction

    function void note_transfer(logic kind, logic [7:0] data);
      logic [31:0] size;
      logic [15:0] magic;
      logic [31:0] fn;
      logic        key;
      logic        first;
      logic        last;
      items_taken++;
      if (kind) begin
        queue_result((phase == fcd_pkg::PH_COLLECT && pre_count == 0) ?
                     fcd_pkg::ST_CLEAN : fcd_pkg::ST_TRUNC,
                     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
        phase      = fcd_pkg::PH_COLLECT;
        pre_count  = 0;
        remaining  = '0;
        audio_next = 1'b0;
      end else begin
        case (phase)
          fcd_pkg::PH_COLLECT: begin
            if (pre_count < 5) begin
              pre_bytes[pre_count] = data;
              pre_count++;
            end else begin
              pre_count = 0;
              size  = {pre_bytes[3], pre_bytes[2], pre_bytes[1], pre_bytes[0]};
              magic = {data, pre_bytes[4]};
              if ((magic == fcd_pkg::MAGIC_VIDEO_A || magic == fcd_pkg::MAGIC_VIDEO_B) &&
                  size > fcd_pkg::PREAMBLE_LEN) begin
                fn  = frame_count;
                key = (fn == '0);
                for (int i = 0; i < 5; i++)
                  queue_result(fcd_pkg::ST_BYTE, pre_bytes[i], 1'b0, i == 0, 1'b0,
                               key, fn, size);
                queue_result(fcd_pkg::ST_BYTE, data, 1'b0, 1'b0, 1'b0, key, fn, size);
                frame_count = fn + 32'd1;
                chunk_len   = size;
                remaining   = size - fcd_pkg::PREAMBLE_LEN;
                audio_next  = 1'b0;
                phase       = fcd_pkg::PH_VIDEO;
              end else if (magic == fcd_pkg::MAGIC_AUDIO) begin
                chunk_len  = size;
                remaining  = fcd_pkg::AUDIO_SUB_LEN;
                audio_next = 1'b1;
                phase      = fcd_pkg::PH_SKIP;
              end else begin
                audio_next = 1'b0;
                if (size > fcd_pkg::PREAMBLE_LEN) begin
                  remaining = size - fcd_pkg::PREAMBLE_LEN;
                  phase     = fcd_pkg::PH_SKIP;
                end
              end
            end
          end
          fcd_pkg::PH_VIDEO: begin
            fn   = frame_count - 32'd1;
            last = (remaining <= 32'd1);
            queue_result(fcd_pkg::ST_BYTE, data, 1'b0, 1'b0, last, fn == '0, fn,
                         chunk_len);
            remaining = last ? '0 : remaining - 32'd1;
            if (last) phase = fcd_pkg::PH_COLLECT;
          end
          fcd_pkg::PH_AUDIO: begin
            first = (remaining == chunk_len);
            last  = (remaining <= 32'd1);
            queue_result(fcd_pkg::ST_BYTE, data, 1'b1, first, last, 1'b1, '0, chunk_len);
            remaining = last ? '0 : remaining - 32'd1;
            if (last) begin
              phase      = fcd_pkg::PH_COLLECT;
              audio_next = 1'b0;
            end
          end
          default: begin
            if (remaining > 32'd1) begin
              remaining--;
            end else begin
              remaining = '0;
              phase     = fcd_pkg::PH_COLLECT;
              if (audio_next) begin
                if (chunk_len == '0) begin
                  queue_result(fcd_pkg::ST_EMPTY, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0);
                  audio_next = 1'b0;
                end else begin
                  remaining = chunk_len;
                  phase     = fcd_pkg::PH_AUDIO;
                end
              end
            end
          end
        endcase
      end
    endfunction

    task check_result(chunk_result_t got);
      chunk_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d byte %02h",
                                  got.status, got.data));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.data !== want.data)
        report_mismatch($sformatf("byte_out %02h, want %02h", got.data, want.data));
      if (got.audio !== want.audio)
        report_mismatch($sformatf("stream_is_audio %0b, want %0b", got.audio, want.audio));
      if (got.first !== want.first)
        report_mismatch($sformatf("first_of_packet %0b, want %0b", got.first, want.first));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_of_packet %0b, want %0b", got.last, want.last));
      if (got.key !== want.key)
        report_mismatch($sformatf("keyframe %0b, want %0b", got.key, want.key));
      if (got.fn !== want.fn)
        report_mismatch($sformatf("frame_idx %08h, want %08h", got.fn, want.fn));
      if (got.size !== want.size)
        report_mismatch($sformatf("packet_size %08h, want %08h", got.size, want.size));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_byte_out;
  logic        out_stream_is_audio;
  logic        out_first_of_packet;
  logic        out_last_of_packet;
  logic        out_keyframe;
  logic [31:0] out_frame_idx;
  logic [31:0] out_packet_size;

  int unsigned send_idle_pct  = 29;
  int unsigned recv_stall_pct = 46;
  int unsigned cycle_count    = 0;

  chunk_stream_checker checker_h = new();

  flic_chunk_deframer_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) checker_h.note_transfer(in_kind, in_data);
      if (out_valid && !out_stall)
        checker_h.check_result({out_status, out_byte_out, out_stream_is_audio,
                                out_first_of_packet, out_last_of_packet, out_keyframe,
                                out_frame_idx, out_packet_size});
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_preamble(input logic [31:0] size, input logic [15:0] magic);
    send_item(1'b0, size[7:0]);
    send_item(1'b0, size[15:8]);
    send_item(1'b0, size[23:16]);
    send_item(1'b0, size[31:24]);
    send_item(1'b0, magic[7:0]);
    send_item(1'b0, magic[15:8]);
  endtask

  task automatic send_chunk();
    logic [7:0]  chunk_bytes [$];
    logic [31:0] size;
    logic [15:0] magic;
    int unsigned sel;
    int unsigned body;
    int unsigned n_send;
    bit          close_with_end;
    sel            = $urandom_range(99);
    close_with_end = 1'b0;
    if (sel >= 92) begin
      send_item(1'b1, 8'($urandom));
      return;
    end
    if (sel >= 84) begin
      // noise, then resync on the end marker
      repeat ($urandom_range(8, 1)) send_item(1'b0, 8'($urandom));
      send_item(1'b1, 8'($urandom));
      return;
    end
    if (sel < 35) begin
      magic = $urandom_range(1) ? fcd_pkg::MAGIC_VIDEO_A : fcd_pkg::MAGIC_VIDEO_B;
      size  = 32'd7 + $urandom_range(24);
      body  = size - fcd_pkg::PREAMBLE_LEN;
    end else if (sel < 55) begin
      magic = fcd_pkg::MAGIC_AUDIO;
      size  = $urandom_range(12);
      body  = fcd_pkg::AUDIO_SUB_LEN + size;
    end else if (sel < 68) begin
      do magic = 16'($urandom);
      while (magic == fcd_pkg::MAGIC_VIDEO_A || magic == fcd_pkg::MAGIC_VIDEO_B ||
             magic == fcd_pkg::MAGIC_AUDIO);
      size = $urandom_range(14);
      body = (size > fcd_pkg::PREAMBLE_LEN) ? size - fcd_pkg::PREAMBLE_LEN : 0;
    end else if (sel < 76) begin
      magic = $urandom_range(1) ? fcd_pkg::MAGIC_VIDEO_A : fcd_pkg::MAGIC_VIDEO_B;
      size  = $urandom_range(6);
      body  = 0;
    end else begin
      // oversized chunk, always cut short
      case ($urandom_range(2))
        0:       magic = fcd_pkg::MAGIC_VIDEO_B;
        1:       magic = fcd_pkg::MAGIC_AUDIO;
        default: magic = 16'($urandom);
      endcase
      size           = {8'($urandom_range(255, 1)), 24'($urandom)};
      body           = $urandom_range(40);
      close_with_end = 1'b1;
    end
    chunk_bytes = '{size[7:0], size[15:8], size[23:16], size[31:24], magic[7:0], magic[15:8]};
    repeat (body) chunk_bytes.push_back(8'($urandom));
    n_send = chunk_bytes.size();
    if (!close_with_end && $urandom_range(99) < 8) begin
      close_with_end = 1'b1;
      n_send         = $urandom_range(chunk_bytes.size() - 1);
    end
    for (int i = 0; i < n_send; i++) send_item(1'b0, chunk_bytes[i]);
    if (close_with_end) send_item(1'b1, 8'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(1'b1, 8'hFF);
    send_preamble(32'd7, fcd_pkg::MAGIC_VIDEO_A);
    send_item(1'b0, 8'hFF);
    send_preamble(32'd0, fcd_pkg::MAGIC_AUDIO);
    repeat (10) send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'hA5);
    send_item(1'b1, 8'h00);

    while (checker_h.items_taken < 170) send_chunk();
    send_idle_pct  = 46;
    recv_stall_pct = 29;
    while (checker_h.items_taken < 340) send_chunk();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (checker_h.items_taken < 500) send_chunk();

    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_h.due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (checker_h.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hdl/fcd_pkg.sv
hdl/fcd_front.sv
hdl/fcd_queue.sv
hdl/fcd_back.sv
hdl/flic_chunk_deframer_unit.sv
bench/flic_chunk_deframer_unit_test.sv
